FILE: rtl/det_ema_pkg.sv
// Package for the detection EMA tracker: payload structs, register
// indexes, status codes and the fixed-point EMA helper.
// No dependencies.
package det_ema_pkg;

	localparam int unsigned CFG_ADDR_W = 5;

	localparam logic [15:0] DEV_STALE_RST = 16'd250;
	localparam logic [15:0] CON_STALE_RST = 16'd150;
	localparam logic [7:0]  PERIOD_RST    = 8'd2;
	localparam logic [8:0]  BOX_W_RST     = 9'd115;
	localparam logic [8:0]  PT_W_RST      = 9'd141;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		REG_DEV_STALE = 3'd0,
		REG_CON_STALE = 3'd1,
		REG_PERIOD    = 3'd2,
		REG_BOX_W     = 3'd3,
		REG_PT_W      = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ID   = 2'd1,
		ST_RESET    = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_FRAME = 2'd0,
		CLS_BAD   = 2'd1,
		CLS_CLEAR = 2'd2,
		CLS_RSVD  = 2'd3
	} cls_t;

	typedef struct packed {
		logic               action;
		logic [31:0]        frame_number;
		logic [31:0]        time_ms;
		logic               raw_device_valid;
		logic signed [15:0] raw_left;
		logic signed [15:0] raw_top;
		logic signed [15:0] raw_right;
		logic signed [15:0] raw_bottom;
		logic [15:0]        raw_score;
		logic               raw_contact_valid;
		logic signed [15:0] raw_point_x;
		logic signed [15:0] raw_point_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               held_device_valid;
		logic signed [15:0] held_left;
		logic signed [15:0] held_top;
		logic signed [15:0] held_right;
		logic signed [15:0] held_bottom;
		logic [15:0]        held_score;
		logic               held_contact_valid;
		logic signed [15:0] held_point_x;
		logic signed [15:0] held_point_y;
		logic [31:0]        valid_frames;
		logic               contact_due_next;
	} out_item_t;

	typedef struct packed {
		cls_t     cls;
		in_item_t item;
	} cmd_t;

	typedef struct packed {
		logic [15:0] dev_stale;
		logic [15:0] con_stale;
		logic [7:0]  period;
		logic [8:0]  box_w;
		logic [8:0]  pt_w;
	} cfg_t;

	function automatic logic [8:0] weight_sat(input logic [8:0] w);
		return (w > 9'd256) ? 9'd256 : w;
	endfunction

	// Floor of (prev*(256-w) + cur*w) / 256; w is already saturated.
	function automatic logic signed [15:0] ema16(input logic signed [15:0] prev,
			input logic signed [15:0] cur, input logic [8:0] w);
		logic signed [26:0] sum;
		sum = 27'(prev) * 27'($signed({1'b0, 9'd256 - w}))
			+ 27'(cur) * 27'($signed({1'b0, w}));
		return sum[23:8];
	endfunction

endpackage

FILE: rtl/det_ema_front.sv
// Front part: accepts frame transactions, checks the frame id ordering
// and pushes classified commands into a short queue. Uses det_ema_pkg.
module det_ema_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  det_ema_pkg::in_item_t in_data,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output det_ema_pkg::cmd_t     cmd_data
);
	import det_ema_pkg::*;

	cmd_t       queue_q [QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [31:0] last_frame_q;
	logic        seen_q;
	logic        push, pop;
	cmd_t        new_cmd;

	assign in_ready  = (count_q != 2'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_data  = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		new_cmd.item = in_data;
		if (in_data.action) begin
			new_cmd.cls = CLS_CLEAR;
		end else if (seen_q && (in_data.frame_number <= last_frame_q)) begin
			new_cmd.cls = CLS_BAD;
		end else begin
			new_cmd.cls = CLS_FRAME;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			count_q      <= 2'd0;
			last_frame_q <= 32'd0;
			seen_q       <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				case (new_cmd.cls)
					CLS_CLEAR: begin
						seen_q       <= 1'b0;
						last_frame_q <= 32'd0;
					end
					CLS_FRAME: begin
						seen_q       <= 1'b1;
						last_frame_q <= in_data.frame_number;
					end
					default: ;
				endcase
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH)) else $error("command queue overflow");
	a_seen_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push && new_cmd.cls == CLS_FRAME |=> seen_q) else $error("seen flag lost");
	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		push && new_cmd.cls == CLS_CLEAR |=> !seen_q) else $error("clear missed");

endmodule

FILE: rtl/det_ema_back.sv
// Back part: applies commands to the held state (EMA, hold, timeout,
// counters) and registers one result per command. Uses det_ema_pkg.
module det_ema_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  det_ema_pkg::cfg_t      cfg,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  det_ema_pkg::cmd_t      cmd_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output det_ema_pkg::out_item_t out_data
);
	import det_ema_pkg::*;

	logic               dev_held_q, con_held_q;
	logic signed [15:0] box_q [4];
	logic signed [15:0] pt_q [2];
	logic [15:0]        score_q;
	logic [31:0]        dev_time_q, con_time_q, count_q;
	logic [7:0]         phase_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               dev_held_d, con_held_d;
	logic signed [15:0] box_d [4];
	logic signed [15:0] pt_d [2];
	logic [15:0]        score_d;
	logic [31:0]        dev_time_d, con_time_d, count_d;
	logic [7:0]         phase_d, period;
	logic [8:0]         bw, pw;
	logic signed [15:0] raw_box [4];
	logic               take;
	in_item_t           it;

	assign cmd_ready = !out_valid_q || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign it        = cmd_data.item;
	assign bw        = weight_sat(cfg.box_w);
	assign pw        = weight_sat(cfg.pt_w);
	assign period    = (cfg.period == 8'd0) ? 8'd1 : cfg.period;
	assign raw_box[0] = it.raw_left;
	assign raw_box[1] = it.raw_top;
	assign raw_box[2] = it.raw_right;
	assign raw_box[3] = it.raw_bottom;

	always_comb begin
		dev_held_d = dev_held_q;
		con_held_d = con_held_q;
		box_d      = box_q;
		pt_d       = pt_q;
		score_d    = score_q;
		dev_time_d = dev_time_q;
		con_time_d = con_time_q;
		count_d    = count_q;
		phase_d    = phase_q;
		case (cmd_data.cls)
			CLS_CLEAR: begin
				dev_held_d = 1'b0;
				con_held_d = 1'b0;
				for (int i = 0; i < 4; i++) box_d[i] = '0;
				pt_d[0] = '0;
				pt_d[1] = '0;
				score_d    = '0;
				dev_time_d = '0;
				con_time_d = '0;
				count_d    = '0;
				phase_d    = '0;
			end
			CLS_FRAME: begin
				if (it.raw_device_valid) begin
					for (int i = 0; i < 4; i++) begin
						box_d[i] = dev_held_q ? ema16(box_q[i], raw_box[i], bw) : raw_box[i];
					end
					score_d    = it.raw_score;
					dev_held_d = 1'b1;
					dev_time_d = it.time_ms;
					if (count_q != '1) count_d = count_q + 32'd1;
					phase_d = ({1'b0, phase_q} + 9'd1 >= {1'b0, period}) ? 8'd0
						: phase_q + 8'd1;
				end else if (dev_held_q
						&& (it.time_ms - dev_time_q) > {16'd0, cfg.dev_stale}) begin
					dev_held_d = 1'b0;
					for (int i = 0; i < 4; i++) box_d[i] = '0;
					score_d = '0;
				end
				if (!dev_held_d) begin
					con_held_d = 1'b0;
					pt_d[0]    = '0;
					pt_d[1]    = '0;
					con_time_d = '0;
				end else if (it.raw_contact_valid) begin
					pt_d[0]    = con_held_q ? ema16(pt_q[0], it.raw_point_x, pw) : it.raw_point_x;
					pt_d[1]    = con_held_q ? ema16(pt_q[1], it.raw_point_y, pw) : it.raw_point_y;
					con_held_d = 1'b1;
					con_time_d = it.time_ms;
				end else if (con_held_q
						&& (it.time_ms - con_time_q) > {16'd0, cfg.con_stale}) begin
					con_held_d = 1'b0;
					pt_d[0]    = '0;
					pt_d[1]    = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.status <= (cmd_data.cls == CLS_CLEAR) ? ST_RESET
				: (cmd_data.cls == CLS_BAD) ? ST_BAD_ID : ST_OK;
			out_q.held_device_valid  <= dev_held_d;
			out_q.held_left          <= box_d[0];
			out_q.held_top           <= box_d[1];
			out_q.held_right         <= box_d[2];
			out_q.held_bottom        <= box_d[3];
			out_q.held_score         <= score_d;
			out_q.held_contact_valid <= con_held_d;
			out_q.held_point_x       <= pt_d[0];
			out_q.held_point_y       <= pt_d[1];
			out_q.valid_frames       <= count_d;
			out_q.contact_due_next   <= (phase_d == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_held_q  <= 1'b0;
			con_held_q  <= 1'b0;
			box_q       <= '{default: '0};
			pt_q        <= '{default: '0};
			score_q     <= '0;
			dev_time_q  <= '0;
			con_time_q  <= '0;
			count_q     <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				dev_held_q <= dev_held_d;
				con_held_q <= con_held_d;
				box_q      <= box_d;
				pt_q       <= pt_d;
				score_q    <= score_d;
				dev_time_q <= dev_time_d;
				con_time_q <= con_time_d;
				count_q    <= count_d;
				phase_q    <= phase_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_contact_needs_device: assert property (@(posedge clk) disable iff (!arst_n)
		con_held_q |-> dev_held_q) else $error("point held without box");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_data.cls != CLS_CLEAR && count_q == '1 |=> count_q == '1)
		else $error("counter wrapped");
	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_data.cls == CLS_BAD |=> $stable(count_q) && $stable(dev_held_q))
		else $error("bad frame changed state");

endmodule

FILE: rtl/detection_ema_tracker_top.sv
// Top level of the detection EMA tracker: register file, front and back.
// Depends on det_ema_pkg, det_ema_front and det_ema_back.
//
// Usage: frame transactions enter on in_valid/in_ready with payload in_data;
// one result transaction leaves on out_valid/out_ready with out_data for each
// input. Registers are to be written through the APB-style port only while
// idle; the block itself does not enforce this. The result passes through
// two registers, the front queue and the back part's output register.
// Throughput is one transaction per cycle while out_ready stays high, set
// by the combinational state update in the back part (four box and two
// point multiply-add blends in parallel).
// A two-entry queue between front and back lets each side stall alone;
// when the receiver holds out_ready low the result stays, the queue fills
// and in_ready falls once it holds two entries.
// Reset clears all held state and loads register defaults; a reset action
// item clears the stream state but keeps the registers.
module detection_ema_tracker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  det_ema_pkg::in_item_t             in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output det_ema_pkg::out_item_t            out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [det_ema_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import det_ema_pkg::*;

	cfg_t     cfg_q;
	cmd_t     cmd_data;
	logic     cmd_valid, cmd_ready;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_stale <= DEV_STALE_RST;
			cfg_q.con_stale <= CON_STALE_RST;
			cfg_q.period    <= PERIOD_RST;
			cfg_q.box_w     <= BOX_W_RST;
			cfg_q.pt_w      <= PT_W_RST;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0
				&& paddr[CFG_ADDR_W-1:2] <= 3'(REG_PT_W)) begin
			case (idx)
				REG_DEV_STALE: cfg_q.dev_stale <= pwdata[15:0];
				REG_CON_STALE: cfg_q.con_stale <= pwdata[15:0];
				REG_PERIOD:    cfg_q.period    <= pwdata[7:0];
				REG_BOX_W:     cfg_q.box_w     <= pwdata[8:0];
				REG_PT_W:      cfg_q.pt_w      <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEV_STALE: prdata = {16'd0, cfg_q.dev_stale};
			REG_CON_STALE: prdata = {16'd0, cfg_q.con_stale};
			REG_PERIOD:    prdata = {24'd0, cfg_q.period};
			REG_BOX_W:     prdata = {23'd0, cfg_q.box_w};
			REG_PT_W:      prdata = {23'd0, cfg_q.pt_w};
			default:       prdata = 32'd0;
		endcase
	end

	det_ema_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cmd_valid, .cmd_ready, .cmd_data
	);

	det_ema_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .cmd_valid, .cmd_ready, .cmd_data,
		.out_valid, .out_ready, .out_data
	);

endmodule
